### rtl/nsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nsc_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_ERR = 2'd1;
    localparam logic [1:0] ST_END = 2'd2;

    // Characters the parser reacts to
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;

    // Register indexes and reset values
    localparam logic       REG_SENTENCE_TYPE = 1'b0;
    localparam logic       REG_MAX_BODY_LEN  = 1'b1;
    localparam logic [23:0] SENTENCE_TYPE_RST = 24'h474741;
    localparam logic [6:0]  MAX_BODY_LEN_RST  = 7'd100;

    // Shortest body that can hold the type letters
    localparam logic [6:0] MIN_BODY_LEN = 7'd5;
    localparam logic [6:0] TYPE_FIRST   = 7'd2;
    localparam logic [6:0] TYPE_LAST    = 7'd4;

    // Result queue geometry
    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = 2;
    localparam int OUT_CW    = 3;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] computed_checksum;
        logic [7:0] received_checksum;
        logic [6:0] body_length;
        logic       last;
    } t_result;

    // Up to two results per input word; v1 is only set together with v0
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

    // Bit 4 set marks a character that is not an uppercase hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = c - CH_ZERO;
                hex_value = {1'b0, d[3:0]};
            end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
                d = c - CH_UPPER_A + 8'd10;
                hex_value = {1'b0, d[3:0]};
            end else begin
                hex_value = 5'h10;
            end
        end
    endfunction

endpackage

`default_nettype wire

### rtl/nsc_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module nsc_parser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_eos,
    input  wire logic [23:0]   i_sentence_type,
    input  wire logic [6:0]    i_max_body_len,
    output nsc_pkg::t_push     o_push
);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_DIG1 = 2'd2;
    localparam logic [1:0] PH_DIG2 = 2'd3;

    logic [1:0]  r_phase, n_phase;
    logic [7:0]  r_xor, n_xor;
    logic [6:0]  r_count, n_count;
    logic [23:0] r_type, n_type;
    logic [4:0]  r_nibble, n_nibble;

    nsc_pkg::t_result err_res;
    nsc_pkg::t_result end_res;
    logic [4:0]       lo_val;
    logic [7:0]       rx_val;
    logic             clear;

    always_comb begin
        err_res = '{status: nsc_pkg::ST_ERR, computed_checksum: r_xor,
                    received_checksum: 8'h00, body_length: r_count, last: 1'b1};
        end_res = '{status: nsc_pkg::ST_END, computed_checksum: 8'h00,
                    received_checksum: 8'h00, body_length: 7'd0, last: 1'b1};
        lo_val   = nsc_pkg::hex_value(i_byte);
        rx_val   = {r_nibble[3:0], lo_val[3:0]};
        clear    = 1'b0;
        n_phase  = r_phase;
        n_xor    = r_xor;
        n_count  = r_count;
        n_type   = r_type;
        n_nibble = r_nibble;
        o_push   = '0;

        if (i_valid) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_eos) begin
                        o_push.v0 = 1'b1;
                        o_push.r0 = end_res;
                        clear     = 1'b1;
                    end else if (i_byte == nsc_pkg::CH_DOLLAR) begin
                        clear   = 1'b1;
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (i_eos) begin
                        o_push.v0 = 1'b1;
                        o_push.r0 = '{status: nsc_pkg::ST_END, computed_checksum: r_xor,
                                      received_checksum: 8'h00, body_length: r_count,
                                      last: 1'b1};
                        clear     = 1'b1;
                        n_phase   = PH_HUNT;
                    end else if (i_byte == nsc_pkg::CH_STAR) begin
                        if (r_count < nsc_pkg::MIN_BODY_LEN || r_type != i_sentence_type) begin
                            o_push.v0 = 1'b1;
                            o_push.r0 = err_res;
                            clear     = 1'b1;
                            n_phase   = PH_HUNT;
                        end else begin
                            n_phase = PH_DIG1;
                        end
                    end else if (i_byte == nsc_pkg::CH_DOLLAR) begin
                        // restart on a fresh sentence right away
                        o_push.v0 = 1'b1;
                        o_push.r0 = err_res;
                        clear     = 1'b1;
                    end else if (i_byte == nsc_pkg::CH_NEWLINE || i_byte == nsc_pkg::CH_NUL
                                 || r_count >= i_max_body_len) begin
                        o_push.v0 = 1'b1;
                        o_push.r0 = err_res;
                        clear     = 1'b1;
                        n_phase   = PH_HUNT;
                    end else begin
                        n_xor = r_xor ^ i_byte;
                        if (r_count >= nsc_pkg::TYPE_FIRST && r_count <= nsc_pkg::TYPE_LAST) begin
                            n_type = {r_type[15:0], i_byte};
                        end
                        n_count = r_count + 7'd1;
                    end
                end
                default: begin
                    // checksum digits
                    if (i_eos) begin
                        o_push.v0      = 1'b1;
                        o_push.r0      = err_res;
                        o_push.r0.last = 1'b0;
                        o_push.v1      = 1'b1;
                        o_push.r1      = end_res;
                        clear          = 1'b1;
                        n_phase        = PH_HUNT;
                    end else if (i_byte == nsc_pkg::CH_NUL) begin
                        o_push.v0 = 1'b1;
                        o_push.r0 = err_res;
                        clear     = 1'b1;
                        n_phase   = PH_HUNT;
                    end else if (r_phase == PH_DIG1) begin
                        n_nibble = lo_val;
                        n_phase  = PH_DIG2;
                    end else begin
                        o_push.v0 = 1'b1;
                        o_push.r0 = err_res;
                        if (!r_nibble[4] && !lo_val[4]) begin
                            o_push.r0.received_checksum = rx_val;
                            o_push.r0.status = (rx_val == r_xor) ? nsc_pkg::ST_OK
                                                                  : nsc_pkg::ST_ERR;
                        end
                        clear   = 1'b1;
                        n_phase = PH_HUNT;
                    end
                end
            endcase
        end

        if (clear) begin
            n_xor    = 8'h00;
            n_count  = 7'd0;
            n_type   = 24'h000000;
            n_nibble = 5'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_xor    <= 8'h00;
            r_count  <= 7'd0;
            r_type   <= 24'h000000;
            r_nibble <= 5'h00;
        end else begin
            r_phase  <= n_phase;
            r_xor    <= n_xor;
            r_count  <= n_count;
            r_type   <= n_type;
            r_nibble <= n_nibble;
        end
    end

endmodule

`default_nettype wire

### rtl/nsc_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module nsc_out_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  nsc_pkg::t_push     i_push,
    output logic               o_room,
    output logic               o_valid,
    input  wire logic          i_ready,
    output nsc_pkg::t_result   o_result
);

    nsc_pkg::t_result r_mem [nsc_pkg::OUT_DEPTH];

    logic [nsc_pkg::OUT_AW-1:0] r_wr, n_wr;
    logic [nsc_pkg::OUT_AW-1:0] r_rd, n_rd;
    logic [nsc_pkg::OUT_CW-1:0] r_count, n_count;
    logic [nsc_pkg::OUT_AW-1:0] wr_next;
    logic [nsc_pkg::OUT_CW-1:0] push_n;
    logic                       pop;

    always_comb begin
        pop     = o_valid && i_ready;
        push_n  = nsc_pkg::OUT_CW'(i_push.v0) + nsc_pkg::OUT_CW'(i_push.v1);
        wr_next = r_wr + nsc_pkg::OUT_AW'(1);
        n_wr    = r_wr + push_n[nsc_pkg::OUT_AW-1:0];
        n_rd    = pop ? r_rd + nsc_pkg::OUT_AW'(1) : r_rd;
        n_count = r_count + push_n - nsc_pkg::OUT_CW'(pop);
    end

    assign o_valid  = (r_count != '0);
    assign o_room   = (r_count <= nsc_pkg::OUT_CW'(nsc_pkg::OUT_DEPTH - 2));
    assign o_result = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[wr_next] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

### rtl/nmea_sentence_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                     Payload
// s_axis    in   i_s_axis_tvalid/o_..._tready  tdata: byte_value; tuser: end_of_stream
// m_axis    out  o_m_axis_tvalid/i_..._tready  tdata: checksums, length; tuser: status
// cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// One input word per cycle; its results are written into the result queue on the edge that takes the word.
// A word yields zero, one or two results; the four-entry result queue sets the rate:
// input is taken while at least two entries are free, so a steady 1 word/cycle holds
// as long as the sink drains one result per cycle.
// Reset (synchronous, active low) returns to hunting for '$', empties the queue and
// restores the GGA type and a body limit of 100. Config writes are always taken.

module nmea_sentence_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input words
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] byte_value
    input  wire logic        i_s_axis_tuser,   // [0] end_of_stream
    // results
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,   // [7:0] computed_checksum,
                                               // [15:8] received_checksum,
                                               // [22:16] body_length, [23] zero
    output logic [1:0]       o_m_axis_tuser,   // [1:0] status
    output logic             o_m_axis_tlast,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [23:0] i_cfg_data
);

    logic [23:0]      r_sentence_type;
    logic [6:0]       r_max_body_len;
    logic             room;
    logic             in_fire;
    nsc_pkg::t_push   push;
    nsc_pkg::t_result res;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = room;
    assign in_fire         = i_s_axis_tvalid && room;

    // Config registers: write only while the stream is idle; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sentence_type <= nsc_pkg::SENTENCE_TYPE_RST;
            r_max_body_len  <= nsc_pkg::MAX_BODY_LEN_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == nsc_pkg::REG_SENTENCE_TYPE) begin
                r_sentence_type <= i_cfg_data;
            end
            if (i_cfg_index == nsc_pkg::REG_MAX_BODY_LEN) begin
                r_max_body_len <= i_cfg_data[6:0];
            end
        end
    end

    // Sentence state and result generation for each accepted word
    nsc_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (in_fire),
        .i_byte          (i_s_axis_tdata),
        .i_eos           (i_s_axis_tuser),
        .i_sentence_type (r_sentence_type),
        .i_max_body_len  (r_max_body_len),
        .o_push          (push)
    );

    // Hold results until the sink takes them
    nsc_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (res)
    );

    assign o_m_axis_tdata = {1'b0, res.body_length, res.received_checksum,
                             res.computed_checksum};
    assign o_m_axis_tuser = res.status;
    assign o_m_axis_tlast = res.last;

endmodule

`default_nettype wire

### rtl/nsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module nsc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [23:0] o_m_axis_tdata,
    input wire logic [1:0]  o_m_axis_tuser,
    input wire logic        o_m_axis_tlast
);

    // Nothing comes out right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result word valid after reset");

    // A stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result word changed");

    // A valid sentence carries matching checksums
    a_ok_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == nsc_pkg::ST_OK |->
            o_m_axis_tdata[7:0] == o_m_axis_tdata[15:8])
        else $error("valid status with mismatched checksums");

    // End of stream is always the final result of its word
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == nsc_pkg::ST_END |-> o_m_axis_tlast)
        else $error("end result without last");

    // Only defined status codes, and a non-last result is always an error
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tuser <= nsc_pkg::ST_END) &&
            (o_m_axis_tlast || o_m_axis_tuser == nsc_pkg::ST_ERR))
        else $error("bad status on result word");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire

### dv/nmea_sentence_checker_tb.sv
`timescale 1ns / 1ps

module nmea_sentence_checker_tb;

    // Parser phases of the predictor
    typedef enum logic [1:0] {
        SEEK,
        BODY,
        DIGIT_HI,
        DIGIT_LO
    } t_phase;

    // One input word: a character, or the end-of-stream mark
    typedef struct {
        logic [7:0] ch;
        logic       eos;
    } t_word;

    localparam int PHASE_WORDS = 230;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_valid = 1'b0;
    logic [7:0]  s_data = 8'h00;
    logic        s_user = 1'b0;
    logic        m_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = nsc_pkg::REG_SENTENCE_TYPE;
    logic [23:0] cfg_data = 24'h000000;

    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [23:0] o_m_axis_tdata;
    wire  [1:0]  o_m_axis_tuser;
    wire         o_m_axis_tlast;
    wire         o_cfg_ready;

    // Register copies of the predictor
    logic [23:0] want_type  = nsc_pkg::SENTENCE_TYPE_RST;
    logic [6:0]  body_limit = nsc_pkg::MAX_BODY_LEN_RST;

    // Sentence state of the predictor
    t_phase      parse_phase = SEEK;
    logic [7:0]  run_xor     = 8'h00;
    logic [6:0]  run_len     = 7'd0;
    logic [23:0] type_seen   = 24'h000000;
    logic [4:0]  hi_nib      = 5'h00;

    t_word            word_queue[$];
    nsc_pkg::t_result result_queue[$];
    t_word            next_word;

    int unsigned send_idle_pct = 21;
    int unsigned recv_idle_pct = 73;
    int unsigned words_added   = 0;
    int unsigned errors        = 0;

    nmea_sentence_checker u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Checksum predictor
    // ------------------------------------------------------------------

    // Value of an uppercase hex digit; bit 4 flags anything else
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b0, 4'(c - "0")};
        if (c >= "A" && c <= "F")
            return {1'b0, 4'(c - "A" + 8'd10)};
        return 5'h10;
    endfunction

    task automatic add_result(input logic [1:0] st, input logic [7:0] cx,
                              input logic [7:0] rx, input logic [6:0] len,
                              input logic lst);
        nsc_pkg::t_result r;
        begin
            r.status            = st;
            r.computed_checksum = cx;
            r.received_checksum = rx;
            r.body_length       = len;
            r.last              = lst;
            result_queue.push_back(r);
        end
    endtask

    task automatic clear_sentence();
        run_xor   = 8'h00;
        run_len   = 7'd0;
        type_seen = 24'h000000;
        hi_nib    = 5'h00;
    endtask

    // Advance the predictor by one accepted word and queue what it yields
    task automatic advance_checker(input logic [7:0] ch, input logic eos);
        logic [4:0] lo;
        logic [7:0] rx;
        begin
            case (parse_phase)
                SEEK: begin
                    if (eos) begin
                        clear_sentence();
                        add_result(nsc_pkg::ST_END, 8'h00, 8'h00, 7'd0, 1'b1);
                    end else if (ch == nsc_pkg::CH_DOLLAR) begin
                        clear_sentence();
                        parse_phase = BODY;
                    end
                end
                BODY: begin
                    if (eos) begin
                        add_result(nsc_pkg::ST_END, run_xor, 8'h00, run_len, 1'b1);
                        clear_sentence();
                        parse_phase = SEEK;
                    end else if (ch == nsc_pkg::CH_STAR) begin
                        // short body or wrong type: the digits are left to the hunt
                        if (run_len < nsc_pkg::MIN_BODY_LEN || type_seen != want_type) begin
                            add_result(nsc_pkg::ST_ERR, run_xor, 8'h00, run_len, 1'b1);
                            clear_sentence();
                            parse_phase = SEEK;
                        end else begin
                            parse_phase = DIGIT_HI;
                        end
                    end else if (ch == nsc_pkg::CH_DOLLAR) begin
                        // abandon this sentence and open a fresh one at once
                        add_result(nsc_pkg::ST_ERR, run_xor, 8'h00, run_len, 1'b1);
                        clear_sentence();
                    end else if (ch == nsc_pkg::CH_NEWLINE || ch == nsc_pkg::CH_NUL
                                 || run_len >= body_limit) begin
                        add_result(nsc_pkg::ST_ERR, run_xor, 8'h00, run_len, 1'b1);
                        clear_sentence();
                        parse_phase = SEEK;
                    end else begin
                        run_xor = run_xor ^ ch;
                        if (run_len >= nsc_pkg::TYPE_FIRST && run_len <= nsc_pkg::TYPE_LAST)
                            type_seen = {type_seen[15:0], ch};
                        run_len = run_len + 7'd1;
                    end
                end
                default: begin
                    if (eos) begin
                        // the sentence fails first, then the stream ends
                        add_result(nsc_pkg::ST_ERR, run_xor, 8'h00, run_len, 1'b0);
                        add_result(nsc_pkg::ST_END, 8'h00, 8'h00, 7'd0, 1'b1);
                        clear_sentence();
                        parse_phase = SEEK;
                    end else if (ch == nsc_pkg::CH_NUL) begin
                        add_result(nsc_pkg::ST_ERR, run_xor, 8'h00, run_len, 1'b1);
                        clear_sentence();
                        parse_phase = SEEK;
                    end else if (parse_phase == DIGIT_HI) begin
                        hi_nib      = nibble_of(ch);
                        parse_phase = DIGIT_LO;
                    end else begin
                        lo = nibble_of(ch);
                        if (hi_nib[4] || lo[4]) begin
                            add_result(nsc_pkg::ST_ERR, run_xor, 8'h00, run_len, 1'b1);
                        end else begin
                            rx = {hi_nib[3:0], lo[3:0]};
                            add_result((rx == run_xor) ? nsc_pkg::ST_OK : nsc_pkg::ST_ERR,
                                       run_xor, rx, run_len, 1'b1);
                        end
                        clear_sentence();
                        parse_phase = SEEK;
                    end
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    task automatic queue_byte(input logic [7:0] c);
        t_word w;
        begin
            w.ch  = c;
            w.eos = 1'b0;
            word_queue.push_back(w);
            words_added++;
        end
    endtask

    // The byte lane carries junk with the end mark; it must be ignored
    task automatic queue_end();
        t_word w;
        begin
            w.ch  = 8'($urandom_range(255));
            w.eos = 1'b1;
            word_queue.push_back(w);
            words_added++;
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return nsc_pkg::CH_ZERO + 8'(n);
        return nsc_pkg::CH_UPPER_A + 8'(n) - 8'd10;
    endfunction

    // Any byte the body takes as an ordinary character
    function automatic logic [7:0] body_char();
        logic [7:0] c;
        begin
            do begin
                c = 8'($urandom_range(255));
            end while (c == nsc_pkg::CH_DOLLAR || c == nsc_pkg::CH_STAR
                       || c == nsc_pkg::CH_NEWLINE || c == nsc_pkg::CH_NUL);
            return c;
        end
    endfunction

    // A non-NUL byte that is no uppercase hex digit, lowercase hex half the time
    function automatic logic [7:0] odd_digit();
        logic [7:0] c;
        begin
            if ($urandom_range(1) == 0)
                return "a" + 8'($urandom_range(5));
            do begin
                c = 8'($urandom_range(1, 255));
            end while ((c >= nsc_pkg::CH_ZERO && c <= nsc_pkg::CH_NINE)
                       || (c >= nsc_pkg::CH_UPPER_A && c <= nsc_pkg::CH_UPPER_F));
            return c;
        end
    endfunction

    // One sentence, mostly well formed, with a random body and a random ending
    task automatic queue_sentence();
        int unsigned len;
        int unsigned pick;
        int unsigned tail;
        int unsigned bad_pos;
        int unsigned cap;
        logic [7:0]  sum;
        logic [7:0]  c;
        logic [7:0]  hi_c;
        logic [7:0]  lo_c;
        begin
            cap  = (body_limit < 16) ? body_limit : 16;
            pick = $urandom_range(99);
            if (pick < 80)
                len = $urandom_range(5, cap);
            else if (pick < 88)
                len = body_limit;
            else if (pick < 94)
                len = body_limit + 1 + $urandom_range(2);
            else
                len = $urandom_range(4);
            // now and then spoil one type letter
            bad_pos = ($urandom_range(9) == 0) ? $urandom_range(2, 4) : 0;
            sum     = 8'h00;
            tail    = $urandom_range(99);

            queue_byte(nsc_pkg::CH_DOLLAR);
            for (int i = 0; i < len; i++) begin
                if (i >= 2 && i <= 4) begin
                    c = want_type[8 * (4 - i) +: 8];
                    if (i == bad_pos)
                        c = c ^ (8'h01 << $urandom_range(7));
                end else begin
                    c = body_char();
                end
                sum = sum ^ c;
                queue_byte(c);
            end

            hi_c = hex_char(sum[7:4]);
            lo_c = hex_char(sum[3:0]);
            if (tail < 55) begin
                queue_byte(nsc_pkg::CH_STAR);
                queue_byte(hi_c);
                queue_byte(lo_c);
            end else if (tail < 63) begin
                sum = sum ^ 8'($urandom_range(1, 255));
                queue_byte(nsc_pkg::CH_STAR);
                queue_byte(hex_char(sum[7:4]));
                queue_byte(hex_char(sum[3:0]));
            end else if (tail < 71) begin
                if ($urandom_range(1) == 0)
                    hi_c = odd_digit();
                else
                    lo_c = odd_digit();
                queue_byte(nsc_pkg::CH_STAR);
                queue_byte(hi_c);
                queue_byte(lo_c);
            end else if (tail < 75) begin
                queue_byte(nsc_pkg::CH_STAR);
                if ($urandom_range(1) == 0)
                    queue_byte(hi_c);
                queue_byte(nsc_pkg::CH_NUL);
            end else if (tail < 80) begin
                queue_byte(nsc_pkg::CH_STAR);
                if ($urandom_range(1) == 0)
                    queue_byte(hi_c);
                queue_end();
            end else if (tail < 85) begin
                queue_end();
            end else if (tail < 90) begin
                queue_byte(nsc_pkg::CH_NEWLINE);
            end else if (tail < 94) begin
                queue_byte(nsc_pkg::CH_NUL);
            end else begin
                queue_byte(nsc_pkg::CH_DOLLAR);
            end

            // line ending, line noise, or a stream end between sentences
            pick = $urandom_range(99);
            if (pick < 40) begin
                queue_byte(8'h0D);
                queue_byte(nsc_pkg::CH_NEWLINE);
            end else if (pick < 50) begin
                repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(255)));
            end else if (pick < 54) begin
                queue_end();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: hold each word until taken, then pull the next one or idle
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_axis_tready)
                advance_checker(s_data, s_user);
            if (!s_valid || o_s_axis_tready) begin
                if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_word = word_queue.pop_front();
                    s_valid   <= 1'b1;
                    s_data    <= next_word.ch;
                    s_user    <= next_word.eos;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each taken result word with the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_result();
        nsc_pkg::t_result want;
        begin
            if (result_queue.size() == 0) begin
                $error("result word with nothing predicted: status %0d data %06h",
                       o_m_axis_tuser, o_m_axis_tdata);
                errors++;
            end else begin
                want = result_queue.pop_front();
                if (o_m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_m_axis_tuser);
                    errors++;
                end
                if (o_m_axis_tdata[7:0] !== want.computed_checksum) begin
                    $error("computed_checksum: expected %02h, got %02h",
                           want.computed_checksum, o_m_axis_tdata[7:0]);
                    errors++;
                end
                if (o_m_axis_tdata[15:8] !== want.received_checksum) begin
                    $error("received_checksum: expected %02h, got %02h",
                           want.received_checksum, o_m_axis_tdata[15:8]);
                    errors++;
                end
                if (o_m_axis_tdata[22:16] !== want.body_length) begin
                    $error("body_length: expected %0d, got %0d",
                           want.body_length, o_m_axis_tdata[22:16]);
                    errors++;
                end
                if (o_m_axis_tdata[23] !== 1'b0) begin
                    $error("tdata pad bit: expected 0, got %b", o_m_axis_tdata[23]);
                    errors++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_m_axis_tlast);
                    errors++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (rst_n && o_m_axis_tvalid && m_ready)
            check_result();
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------

    // Write one register and mirror it in the predictor; call only when idle
    task automatic write_reg(input logic idx, input logic [23:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == nsc_pkg::REG_SENTENCE_TYPE)
            want_type = value;
        else
            body_limit = value[6:0];
    endtask

    // Wait until every word is taken and every result is in, then let
    // words that yield nothing drain out of the pipeline
    task automatic settle();
        do @(negedge i_clk);
        while (word_queue.size() != 0 || s_valid || result_queue.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic logic [23:0] random_letters();
        return {8'("A" + $urandom_range(25)), 8'("A" + $urandom_range(25)),
                8'("A" + $urandom_range(25))};
    endfunction

    initial begin
        int unsigned target;
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words under the reset settings (GGA, limit 100)
        queue_byte(8'hFF);                  // dropped while hunting
        queue_byte(nsc_pkg::CH_NUL);        // dropped while hunting
        queue_end();                        // end while hunting
        queue_byte(nsc_pkg::CH_DOLLAR);
        queue_byte("A");
        queue_byte(nsc_pkg::CH_NEWLINE);    // newline in body
        queue_byte(nsc_pkg::CH_DOLLAR);
        queue_byte(nsc_pkg::CH_NUL);        // NUL in body
        queue_byte(nsc_pkg::CH_DOLLAR);
        queue_byte("B");
        queue_byte(nsc_pkg::CH_DOLLAR);     // restart inside a body
        queue_end();                        // end inside a body
        queue_byte(nsc_pkg::CH_DOLLAR);
        queue_byte("G");
        queue_byte("P");
        queue_byte(nsc_pkg::CH_STAR);       // body too short for the type
        queue_byte(nsc_pkg::CH_DOLLAR);
        queue_byte("G");
        queue_byte("P");
        queue_byte("G");
        queue_byte("G");
        queue_byte("A");
        queue_byte(nsc_pkg::CH_STAR);
        queue_byte("5");
        queue_byte("6");                    // good sentence, checksum 0x56
        settle();

        target = words_added;
        for (int p = 0; p < 6; p++) begin
            // receiver-heavy idling, then sender-heavy, then none
            if (p < 2) begin
                send_idle_pct = 21;
                recv_idle_pct = 73;
            end else if (p < 4) begin
                send_idle_pct = 73;
                recv_idle_pct = 21;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (p)
                0: begin
                    write_reg(nsc_pkg::REG_SENTENCE_TYPE, {"R", "M", "C"});
                    write_reg(nsc_pkg::REG_MAX_BODY_LEN, 24'd5);
                end
                1: begin
                    write_reg(nsc_pkg::REG_SENTENCE_TYPE, random_letters());
                    write_reg(nsc_pkg::REG_MAX_BODY_LEN, 24'd127);
                end
                2: begin
                    write_reg(nsc_pkg::REG_SENTENCE_TYPE, 24'hFFFFFF);
                    write_reg(nsc_pkg::REG_MAX_BODY_LEN,
                              {17'($urandom), 7'($urandom_range(5, 127))});
                end
                3: begin
                    write_reg(nsc_pkg::REG_SENTENCE_TYPE, random_letters());
                    write_reg(nsc_pkg::REG_MAX_BODY_LEN, 24'd20);
                end
                4: begin
                    write_reg(nsc_pkg::REG_SENTENCE_TYPE, 24'h000000);
                    write_reg(nsc_pkg::REG_MAX_BODY_LEN, 24'($urandom_range(5, 40)));
                end
                default: begin
                    write_reg(nsc_pkg::REG_SENTENCE_TYPE, random_letters());
                    write_reg(nsc_pkg::REG_MAX_BODY_LEN, 24'($urandom_range(5, 127)));
                end
            endcase
            @(negedge i_clk);
            target += PHASE_WORDS;
            while (words_added < target)
                queue_sentence();
            settle();
        end

        if (errors == 0)
            $display("nmea_sentence_checker verification clean");
        else
            $display("nmea_sentence_checker verification failed");
        $finish;
    end

    // Run limit, far above the slowest correct run
    initial begin
        #2000000;
        $display("nmea_sentence_checker verification failed");
        $finish;
    end

endmodule
